@@ sv/lwe_pkg.sv @@
// ----------------------------------------------------------------------------
// lwe_pkg
// Shared types, codes and helpers of the display window pixel stream encoder.
// ----------------------------------------------------------------------------
package lwe_pkg;

  localparam int unsigned COORD_BITS_DEF = 10;
  localparam int unsigned CFG_W          = 11;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned WORD_W         = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS    = 2'd1;

  localparam logic [CFG_W-1:0] SCREEN_COLUMNS_RST = 11'd480;
  localparam logic [CFG_W-1:0] SCREEN_ROWS_RST    = 11'd320;

  localparam logic [2:0] ACT_WINDOW   = 3'd0;
  localparam logic [2:0] ACT_PIXEL    = 3'd1;
  localparam logic [2:0] ACT_GLYPH    = 3'd2;
  localparam logic [2:0] ACT_RAW_CMD  = 3'd3;
  localparam logic [2:0] ACT_RAW_DATA = 3'd4;

  localparam logic [7:0] CMD_COLUMN = 8'h2A;
  localparam logic [7:0] CMD_ROW    = 8'h2B;
  localparam logic [7:0] CMD_WRITE  = 8'h2C;
  localparam logic [7:0] RED_MASK   = 8'hF8;
  localparam logic [7:0] GREEN_MASK = 8'hFC;

  localparam logic [3:0] WINDOW_LAST = 4'd10;
  localparam logic [1:0] CHAN_LAST   = 2'd2;
  localparam logic [2:0] PIX_LAST    = 3'd7;

  typedef enum logic [1:0] {
    KIND_WINDOW,
    KIND_PIXEL,
    KIND_GLYPH,
    KIND_RAW
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              is_data;
    logic [7:0]        bits;
    logic [15:0]       fore_color;
    logic [15:0]       back_color;
    logic [WORD_W-1:0] x_start;
    logic [WORD_W-1:0] x_end;
    logic [WORD_W-1:0] y_start;
    logic [WORD_W-1:0] y_end;
  } job_t;

  function automatic logic [7:0] color_byte(input logic [15:0] c, input logic [1:0] chan);
    logic [7:0] b;
    case (chan)
      2'd0:    b = 8'(c >> 8) & RED_MASK;
      2'd1:    b = 8'(c >> 3) & GREEN_MASK;
      default: b = 8'(c << 3);
    endcase
    return b;
  endfunction

endpackage

@@ sv/lwe_front.sv @@
// ----------------------------------------------------------------------------
// lwe_front
// Takes drawing items, checks windows against the screen size, tracks the
// window state and queues a job for every item that produces bytes.
// ----------------------------------------------------------------------------
module lwe_front #(
  parameter int unsigned COORD_BITS = lwe_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lwe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lwe_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    action_i,
  input  logic [COORD_BITS-1:0]         x_start_i,
  input  logic [COORD_BITS-1:0]         y_start_i,
  input  logic [COORD_BITS:0]           span_columns_i,
  input  logic [COORD_BITS:0]           span_rows_i,
  input  logic [15:0]                   fore_color_i,
  input  logic [15:0]                   back_color_i,
  input  logic [7:0]                    bits_i,
  input  logic                          full_i,
  output logic                          push_o,
  output lwe_pkg::job_t                 job_o
);

  localparam int unsigned SUM_W = COORD_BITS + 2;

  logic [lwe_pkg::CFG_W-1:0] screen_columns_q;
  logic [lwe_pkg::CFG_W-1:0] screen_rows_q;
  logic                      window_accepted_q;
  logic                      window_accepted_d;
  logic [SUM_W-1:0]          x_sum;
  logic [SUM_W-1:0]          y_sum;
  logic [SUM_W-1:0]          x_end;
  logic [SUM_W-1:0]          y_end;
  logic                      window_ok;
  logic                      emit;
  logic                      take;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign take        = in_valid_i && in_ready_o;

  assign x_sum = SUM_W'(x_start_i) + SUM_W'(span_columns_i);
  assign y_sum = SUM_W'(y_start_i) + SUM_W'(span_rows_i);
  assign x_end = x_sum - SUM_W'(1);
  assign y_end = y_sum - SUM_W'(1);

  assign window_ok = (span_columns_i != '0) && (span_rows_i != '0) &&
                     (x_sum <= SUM_W'(screen_columns_q)) &&
                     (y_sum <= SUM_W'(screen_rows_q));

  always_comb begin
    emit              = 1'b0;
    window_accepted_d = window_accepted_q;
    job_o.kind        = lwe_pkg::KIND_RAW;
    job_o.is_data     = 1'b0;
    job_o.bits        = bits_i;
    job_o.fore_color  = fore_color_i;
    job_o.back_color  = back_color_i;
    job_o.x_start     = lwe_pkg::WORD_W'(x_start_i);
    job_o.x_end       = lwe_pkg::WORD_W'(x_end);
    job_o.y_start     = lwe_pkg::WORD_W'(y_start_i);
    job_o.y_end       = lwe_pkg::WORD_W'(y_end);
    unique case (action_i)
      lwe_pkg::ACT_WINDOW: begin
        window_accepted_d = window_ok;
        emit              = window_ok;
        job_o.kind        = lwe_pkg::KIND_WINDOW;
      end
      lwe_pkg::ACT_PIXEL: begin
        emit       = window_accepted_q;
        job_o.kind = lwe_pkg::KIND_PIXEL;
      end
      lwe_pkg::ACT_GLYPH: begin
        emit       = window_accepted_q;
        job_o.kind = lwe_pkg::KIND_GLYPH;
      end
      lwe_pkg::ACT_RAW_CMD: begin
        emit = 1'b1;
      end
      lwe_pkg::ACT_RAW_DATA: begin
        emit          = 1'b1;
        job_o.is_data = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push_o = take && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_columns_q  <= lwe_pkg::SCREEN_COLUMNS_RST;
      screen_rows_q     <= lwe_pkg::SCREEN_ROWS_RST;
      window_accepted_q <= 1'b1;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == lwe_pkg::REG_SCREEN_COLUMNS) begin
          screen_columns_q <= cfg_data_i;
        end else if (cfg_index_i == lwe_pkg::REG_SCREEN_ROWS) begin
          screen_rows_q <= cfg_data_i;
        end
      end
      if (take) begin
        window_accepted_q <= window_accepted_d;
      end
    end
  end

endmodule

@@ sv/lwe_queue.sv @@
// ----------------------------------------------------------------------------
// lwe_queue
// Two-entry job queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module lwe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lwe_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lwe_pkg::job_t job_o
);

  lwe_pkg::job_t mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ sv/lwe_back.sv @@
// ----------------------------------------------------------------------------
// lwe_back
// Byte sequencer: walks the head job into the output register one byte per
// cycle unless out_ready_i stalls it; releases the job on its final byte.
// ----------------------------------------------------------------------------
module lwe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  lwe_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    link_byte_o,
  output logic          is_data_o,
  output logic          last_o
);

  logic [3:0]  cnt_q;
  logic [1:0]  chan_q;
  logic [2:0]  pix_q;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        is_data_q;
  logic        last_q;
  logic [7:0]  byte_d;
  logic        is_data_d;
  logic        last_d;
  logic [7:0]  win_byte;
  logic        win_data;
  logic [15:0] pix_color;
  logic        step;

  assign step  = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = step && last_d;

  // window sequence: column cmd, start, end, row cmd, start, end, write cmd
  always_comb begin
    win_data = 1'b1;
    case (cnt_q)
      4'd0: begin
        win_byte = lwe_pkg::CMD_COLUMN;
        win_data = 1'b0;
      end
      4'd1:    win_byte = job_i.x_start[15:8];
      4'd2:    win_byte = job_i.x_start[7:0];
      4'd3:    win_byte = job_i.x_end[15:8];
      4'd4:    win_byte = job_i.x_end[7:0];
      4'd5: begin
        win_byte = lwe_pkg::CMD_ROW;
        win_data = 1'b0;
      end
      4'd6:    win_byte = job_i.y_start[15:8];
      4'd7:    win_byte = job_i.y_start[7:0];
      4'd8:    win_byte = job_i.y_end[15:8];
      4'd9:    win_byte = job_i.y_end[7:0];
      default: begin
        win_byte = lwe_pkg::CMD_WRITE;
        win_data = 1'b0;
      end
    endcase
  end

  // glyph bits go msb first
  assign pix_color = job_i.bits[3'd7 - pix_q] ? job_i.fore_color : job_i.back_color;

  always_comb begin
    unique case (job_i.kind)
      lwe_pkg::KIND_WINDOW: begin
        byte_d    = win_byte;
        is_data_d = win_data;
        last_d    = (cnt_q == lwe_pkg::WINDOW_LAST);
      end
      lwe_pkg::KIND_PIXEL: begin
        byte_d    = lwe_pkg::color_byte(job_i.fore_color, chan_q);
        is_data_d = 1'b1;
        last_d    = (chan_q == lwe_pkg::CHAN_LAST);
      end
      lwe_pkg::KIND_GLYPH: begin
        byte_d    = lwe_pkg::color_byte(pix_color, chan_q);
        is_data_d = 1'b1;
        last_d    = (chan_q == lwe_pkg::CHAN_LAST) && (pix_q == lwe_pkg::PIX_LAST);
      end
      default: begin
        byte_d    = job_i.bits;
        is_data_d = job_i.is_data;
        last_d    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 4'd0;
      chan_q      <= 2'd0;
      pix_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
        if (last_d) begin
          cnt_q  <= 4'd0;
          chan_q <= 2'd0;
          pix_q  <= 3'd0;
        end else begin
          cnt_q <= cnt_q + 4'd1;
          if (chan_q == lwe_pkg::CHAN_LAST) begin
            chan_q <= 2'd0;
            pix_q  <= pix_q + 3'd1;
          end else begin
            chan_q <= chan_q + 2'd1;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q    <= byte_d;
      is_data_q <= is_data_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign link_byte_o = byte_q;
  assign is_data_o   = is_data_q;
  assign last_o      = last_q;

endmodule

@@ sv/lcd_window_pixel_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// lcd_window_pixel_stream_encoder
// Path: an item is queued as a job, then the sequencer registers its bytes.
// The sequencer gives one byte per cycle unless out_ready_i stalls it; the
//   bytes per item are raw 1, pixel 3, window 11, glyph 24.
// Input is taken every cycle while the two-entry job queue has room.
// Reset: screen 480 x 320, window state accepted, queue and output empty.
// ----------------------------------------------------------------------------
module lcd_window_pixel_stream_encoder #(
  parameter int unsigned COORD_BITS = lwe_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lwe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lwe_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    action_i,
  input  logic [COORD_BITS-1:0]         x_start_i,
  input  logic [COORD_BITS-1:0]         y_start_i,
  input  logic [COORD_BITS:0]           span_columns_i,
  input  logic [COORD_BITS:0]           span_rows_i,
  input  logic [15:0]                   fore_color_i,
  input  logic [15:0]                   back_color_i,
  input  logic [7:0]                    bits_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    link_byte_o,
  output logic                          is_data_o,
  output logic                          last_o
);

  logic          full;
  logic          push;
  logic          pop;
  logic          head_valid;
  lwe_pkg::job_t push_job;
  lwe_pkg::job_t head_job;

  lwe_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .span_columns_i(span_columns_i),
    .span_rows_i   (span_rows_i),
    .fore_color_i  (fore_color_i),
    .back_color_i  (back_color_i),
    .bits_i        (bits_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  lwe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .job_o  (head_job)
  );

  lwe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (head_valid),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .link_byte_o(link_byte_o),
    .is_data_o  (is_data_o),
    .last_o     (last_o)
  );

endmodule
